@@ src/vit_pkg.sv @@
// ----------------------------------------------------------------------------
// vit_pkg
// Shared types, constants and helpers of the vector interning table.
// ----------------------------------------------------------------------------
package vit_pkg;

  localparam int unsigned MAX_AGENTS  = 8;
  localparam int unsigned KEY_WORDS   = MAX_AGENTS - 1;
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned BUCKETS     = 2 * TABLE_DEPTH;
  localparam int unsigned KEY_ENTRIES = TABLE_DEPTH * KEY_WORDS;

  localparam int unsigned VAL_W  = 31;
  localparam int unsigned ID_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned BKT_W  = $clog2(BUCKETS);
  localparam int unsigned KADR_W = $clog2(KEY_ENTRIES);
  localparam int unsigned POS_W  = $clog2(MAX_AGENTS);
  localparam int unsigned NUM_W  = $clog2(MAX_AGENTS + 1);
  localparam int unsigned KIX_W  = $clog2(KEY_WORDS);

  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_GET    = 1'b1;

  localparam logic CFG_AGENT_COUNT = 1'b0;
  localparam logic CFG_OWN_AGENT   = 1'b1;

  typedef enum logic [1:0] {
    FAULT_OK        = 2'd0,
    FAULT_FULL      = 2'd1,
    FAULT_UNWRITTEN = 2'd2
  } fault_e;

  typedef enum logic [3:0] {
    BK_IDLE, BK_HASH, BK_BRD, BK_BCHK, BK_CRD, BK_CCHK, BK_KWR, BK_GRD, BK_GOUT
  } back_state_e;

  typedef struct packed {
    logic             action;
    logic [VAL_W-1:0] element_value;
    logic             element_last;
    logic [ID_W-1:0]  lookup_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]    entry_id;
    logic               was_new;
    logic signed [31:0] out_value;
    logic               out_last;
    logic [1:0]         fault;
  } res_t;

  typedef struct packed {
    logic [NUM_W-1:0] agents;
    logic [POS_W-1:0] own;
  } cfg_t;

  typedef logic [KEY_WORDS-1:0][VAL_W-1:0] key_t;

  typedef struct packed {
    logic            is_get;
    logic [ID_W-1:0] id;
    key_t            key;
  } job_t;

  function automatic logic [NUM_W-1:0] agents_eff(input logic [3:0] ac);
    logic [NUM_W-1:0] n;
    if (ac == 4'd0) n = NUM_W'(1);
    else if (ac > 4'(MAX_AGENTS)) n = NUM_W'(MAX_AGENTS);
    else n = NUM_W'(ac);
    return n;
  endfunction

  function automatic logic [POS_W-1:0] own_eff(input logic [NUM_W-1:0] n,
                                               input logic [2:0] o);
    logic [NUM_W-1:0] lim;
    lim = n - NUM_W'(1);
    if (NUM_W'(o) > lim) return POS_W'(lim);
    return POS_W'(o);
  endfunction

  function automatic logic [KADR_W-1:0] key_addr(input logic [ID_W-1:0] e,
                                                 input logic [KIX_W-1:0] w);
    return (KADR_W'(e) * KADR_W'(KEY_WORDS)) + KADR_W'(w);
  endfunction

endpackage

@@ src/vit_front.sv @@
// ----------------------------------------------------------------------------
// vit_front
// Collects insert elements into a partial key and issues jobs to the queue.
// ----------------------------------------------------------------------------
module vit_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  vit_pkg::req_t req_i,
  input  vit_pkg::cfg_t cfg_i,
  input  logic          flush_i,
  output logic          push_o,
  output vit_pkg::job_t job_o
);
  import vit_pkg::*;

  key_t             key_q, key_d, key_w;
  logic [NUM_W-1:0] pos_q, pos_d;
  logic [NUM_W-1:0] slot;

  always_comb begin
    key_w = key_q;
    pos_d = pos_q;
    slot  = (pos_q < NUM_W'(cfg_i.own)) ? pos_q : pos_q - NUM_W'(1);
    if (pos_q < cfg_i.agents) begin
      if (pos_q != NUM_W'(cfg_i.own)) key_w[KIX_W'(slot)] = req_i.element_value;
      pos_d = pos_q + NUM_W'(1);
    end
    key_d      = key_q;
    push_o     = 1'b0;
    job_o      = '0;
    job_o.id   = req_i.lookup_id;
    job_o.key  = key_w;
    if (accept_i) begin
      if (req_i.action == ACT_GET) begin
        push_o       = 1'b1;
        job_o.is_get = 1'b1;
        pos_d        = pos_q;
      end else if (req_i.element_last) begin
        push_o = 1'b1;
        key_d  = '0;
        pos_d  = '0;
      end else begin
        key_d = key_w;
      end
    end else begin
      pos_d = pos_q;
    end
    if (flush_i) begin
      key_d = '0;
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      pos_q <= '0;
    end else begin
      key_q <= key_d;
      pos_q <= pos_d;
    end
  end

endmodule

@@ src/vit_queue.sv @@
// ----------------------------------------------------------------------------
// vit_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module vit_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vit_pkg::job_t job_i,
  input  logic          pop_i,
  output vit_pkg::job_t head_o,
  output logic          empty_o,
  output logic          full_o
);
  import vit_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign head_o  = mem_q[rp_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

@@ src/vit_back.sv @@
// ----------------------------------------------------------------------------
// vit_back
// Hashes keys, probes the bucket store, interns new keys and reads vectors.
// ----------------------------------------------------------------------------
module vit_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vit_pkg::cfg_t cfg_i,
  input  logic          flush_i,
  input  logic          empty_i,
  input  vit_pkg::job_t head_i,
  output logic          pop_o,
  output logic          clearing_o,
  output logic          done_o,
  output vit_pkg::res_t result_o
);
  import vit_pkg::*;

  logic [VAL_W-1:0] key_mem [KEY_ENTRIES];
  logic [BKT_W-1:0] bkt_mem [BUCKETS];
  logic [VAL_W-1:0] key_rd_q;
  logic [BKT_W-1:0] bkt_rd_q;

  back_state_e      state_q, state_d;
  job_t             job_q, job_d;
  logic [31:0]      h_q, h_d;
  logic [KIX_W:0]   k_q, k_d;
  logic [BKT_W-1:0] b_q, b_d, slot_q, slot_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0] p_q, p_d;
  logic [KIX_W-1:0] j_q, j_d;
  logic             clr_q, clr_d;
  logic [BKT_W-1:0] ci_q, ci_d;
  logic             done_q, done_d;
  res_t             res_q, res_d;

  logic              key_we, bkt_we;
  logic [KADR_W-1:0] key_waddr, key_raddr;
  logic [VAL_W-1:0]  key_wdata;
  logic [BKT_W-1:0]  bkt_waddr, bkt_raddr, bkt_wdata;
  logic [KIX_W:0]    len;
  logic [KIX_W-1:0]  kk;
  logic [ID_W-1:0]   sid;

  assign len        = (KIX_W + 1)'(cfg_i.agents - NUM_W'(1));
  assign kk         = KIX_W'(k_q);
  assign sid        = ID_W'(slot_q - BKT_W'(1));
  assign clearing_o = clr_q;
  assign done_o     = done_q;
  assign result_o   = res_q;

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    h_d       = h_q;
    k_d       = k_q;
    b_d       = b_q;
    slot_d    = slot_q;
    cnt_d     = cnt_q;
    p_d       = p_q;
    j_d       = j_q;
    clr_d     = clr_q;
    ci_d      = ci_q;
    done_d    = 1'b0;
    res_d     = res_q;
    pop_o     = 1'b0;
    key_we    = 1'b0;
    key_waddr = key_addr(ID_W'(cnt_q), kk);
    key_wdata = job_q.key[kk];
    key_raddr = key_addr(sid, kk);
    bkt_we    = 1'b0;
    bkt_waddr = b_q;
    bkt_wdata = BKT_W'(cnt_q) + BKT_W'(1);
    bkt_raddr = b_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i && !clr_q) begin
          pop_o = 1'b1;
          job_d = head_i;
          if (head_i.is_get) begin
            if (CNT_W'(head_i.id) >= cnt_q) begin
              done_d = 1'b1;
              res_d  = '0;
              res_d.out_last = 1'b1;
              res_d.fault    = FAULT_UNWRITTEN;
            end else begin
              p_d     = '0;
              j_d     = '0;
              state_d = BK_GRD;
            end
          end else begin
            h_d     = FNV_OFFSET;
            k_d     = '0;
            state_d = BK_HASH;
          end
        end
      end
      BK_HASH: begin
        if (k_q == len) begin
          b_d     = h_q[BKT_W-1:0];
          state_d = BK_BRD;
        end else begin
          h_d = 32'((h_q ^ {1'b0, job_q.key[kk]}) * FNV_PRIME);
          k_d = k_q + (KIX_W + 1)'(1);
        end
      end
      BK_BRD: begin
        state_d = BK_BCHK;
      end
      BK_BCHK: begin
        k_d = '0;
        if (bkt_rd_q == '0) begin
          if (cnt_q >= CNT_W'(TABLE_DEPTH)) begin
            done_d = 1'b1;
            res_d  = '0;
            res_d.out_last = 1'b1;
            res_d.fault    = FAULT_FULL;
            state_d = BK_IDLE;
          end else begin
            state_d = BK_KWR;
          end
        end else begin
          slot_d  = bkt_rd_q;
          state_d = BK_CRD;
        end
      end
      BK_CRD: begin
        if (k_q == len) begin
          done_d = 1'b1;
          res_d  = '0;
          res_d.entry_id = sid;
          res_d.out_last = 1'b1;
          state_d = BK_IDLE;
        end else begin
          state_d = BK_CCHK;
        end
      end
      BK_CCHK: begin
        if (key_rd_q == job_q.key[kk]) begin
          k_d     = k_q + (KIX_W + 1)'(1);
          state_d = BK_CRD;
        end else begin
          b_d     = b_q + BKT_W'(1);
          state_d = BK_BRD;
        end
      end
      BK_KWR: begin
        if (k_q == len) begin
          bkt_we = 1'b1;
          done_d = 1'b1;
          res_d  = '0;
          res_d.entry_id = ID_W'(cnt_q);
          res_d.was_new  = 1'b1;
          res_d.out_last = 1'b1;
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = BK_IDLE;
        end else begin
          key_we = 1'b1;
          k_d    = k_q + (KIX_W + 1)'(1);
        end
      end
      BK_GRD: begin
        key_raddr = key_addr(job_q.id, j_q);
        state_d   = BK_GOUT;
      end
      BK_GOUT: begin
        done_d = 1'b1;
        res_d  = '0;
        res_d.entry_id = job_q.id;
        if (p_q == cfg_i.own) begin
          res_d.out_value = -32'sd1;
        end else begin
          res_d.out_value = $signed({1'b0, key_rd_q});
          j_d = j_q + KIX_W'(1);
        end
        if (NUM_W'(p_q) == cfg_i.agents - NUM_W'(1)) begin
          res_d.out_last = 1'b1;
          state_d = BK_IDLE;
        end else begin
          p_d     = p_q + POS_W'(1);
          state_d = BK_GRD;
        end
      end
      default: state_d = BK_IDLE;
    endcase
    if (clr_q) begin
      bkt_we    = 1'b1;
      bkt_waddr = ci_q;
      bkt_wdata = '0;
      ci_d      = ci_q + BKT_W'(1);
      if (ci_q == BKT_W'(BUCKETS - 1)) clr_d = 1'b0;
    end
    if (flush_i) begin
      clr_d   = 1'b1;
      ci_d    = '0;
      cnt_d   = '0;
      state_d = BK_IDLE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_waddr] <= key_wdata;
    key_rd_q <= key_mem[key_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (bkt_we) bkt_mem[bkt_waddr] <= bkt_wdata;
    bkt_rd_q <= bkt_mem[bkt_raddr];
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    h_q    <= h_d;
    b_q    <= b_d;
    slot_q <= slot_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      k_q     <= '0;
      cnt_q   <= '0;
      p_q     <= '0;
      j_q     <= '0;
      clr_q   <= 1'b1;
      ci_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      p_q     <= p_d;
      j_q     <= j_d;
      clr_q   <= clr_d;
      ci_q    <= ci_d;
      done_q  <= done_d;
    end
  end

`ifndef SYNTH
  a_fault_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && res_q.fault != FAULT_OK |-> res_q.out_last)
    else $error("fault result not marked last");
  a_new_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && res_q.was_new |-> res_q.fault == FAULT_OK && res_q.out_last)
    else $error("new entry result malformed");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");
  a_no_work_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !pop_o)
    else $error("job taken during clearing pass");
`endif

endmodule

@@ src/vector_interning_table.sv @@
// ----------------------------------------------------------------------------
// vector_interning_table
// Interns vectors of per-agent state ids and reads them back by dense id.
// ----------------------------------------------------------------------------
// After reset and after every configuration write the bucket store is cleared
// while busy is high. An insert element is taken when start is high and busy
// is low; the marked last element queues a lookup over len key words that is
// popped and hashed, then probes buckets, reading each and comparing the key it
// holds word by word, then reports a known key, stores a new one word by word
// in the key memory or reports a full table; the result is registered. A get
// reads the stored key back one position at a time. A two-entry job queue lets
// requests arrive while the back end works; busy rises when it is full or while
// the bucket store is cleared. Results appear on result_o for one cycle with
// done_o high and cannot be stalled.
module vector_interning_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  vit_pkg::req_t req_i,
  output logic          done_o,
  output vit_pkg::res_t result_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_index_i,
  input  logic [3:0]    cfg_data_i
);
  import vit_pkg::*;

  logic [3:0] ac_q;
  logic [2:0] own_q;
  cfg_t       cfg;
  logic       flush, accept, push, pop, empty, full, clearing;
  job_t       job, head;

  assign cfg_ready_o = 1'b1;
  assign flush       = cfg_valid_i;
  assign busy        = full | clearing;
  assign accept      = start & ~busy;
  assign cfg.agents  = agents_eff(ac_q);
  assign cfg.own     = own_eff(cfg.agents, own_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac_q  <= 4'd2;
      own_q <= 3'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_AGENT_COUNT: ac_q  <= cfg_data_i;
        CFG_OWN_AGENT:   own_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  vit_front u_front (
    .clk_i, .rst_ni, .accept_i(accept), .req_i, .cfg_i(cfg), .flush_i(flush),
    .push_o(push), .job_o(job)
  );

  vit_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(job), .pop_i(pop),
    .head_o(head), .empty_o(empty), .full_o(full)
  );

  vit_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .flush_i(flush), .empty_i(empty),
    .head_i(head), .pop_o(pop), .clearing_o(clearing), .done_o, .result_o
  );

endmodule
